FILE: rtl/uvs_pkg.sv
// Shared types and constants for the UV sphere quad tessellator.
// No dependencies; used by every module of the block.
package uvs_pkg;

    localparam int CORDIC_MAX_STEPS = 24;
    localparam int DIV_STEPS        = 17;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_SLICES = 2'd2;

    // per vertex slot: bit k set when slot k steps one row / one column on
    localparam logic [5:0] ROW_STEP  = 6'b011010;
    localparam logic [5:0] COL_STEP  = 6'b110100;
    localparam logic [2:0] LAST_SLOT = 3'd5;

    typedef logic signed [17:0] trig_t;
    typedef logic signed [16:0] coord_t;

    // arctangent of 2^-k in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] res;
        case (k)
            5'd0:    res = 32'h20000000;
            5'd1:    res = 32'h12E4051E;
            5'd2:    res = 32'h09FB385B;
            5'd3:    res = 32'h051111D4;
            5'd4:    res = 32'h028B0D43;
            5'd5:    res = 32'h0145D7E1;
            5'd6:    res = 32'h00A2F61E;
            5'd7:    res = 32'h00517C55;
            5'd8:    res = 32'h0028BE53;
            5'd9:    res = 32'h00145F2F;
            5'd10:   res = 32'h000A2F98;
            5'd11:   res = 32'h000517CC;
            5'd12:   res = 32'h00028BE6;
            5'd13:   res = 32'h000145F3;
            5'd14:   res = 32'h0000A2FA;
            5'd15:   res = 32'h0000517D;
            5'd16:   res = 32'h000028BE;
            5'd17:   res = 32'h0000145F;
            5'd18:   res = 32'h00000A30;
            5'd19:   res = 32'h00000518;
            5'd20:   res = 32'h0000028C;
            5'd21:   res = 32'h00000146;
            5'd22:   res = 32'h000000A3;
            5'd23:   res = 32'h00000051;
            default: res = 32'h00000000;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/uvs_div.sv
// Pipelined restoring divider: quot = (num*65536 + den/2) / den, one bit a stage.
// Depends on uvs_pkg.
module uvs_div
    import uvs_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [8:0]  num,
    input  logic [8:0]  den,
    output logic [16:0] quot
);

    logic [8:0]  rem_reg  [0:DIV_STEPS-1];
    logic [16:0] low_reg  [0:DIV_STEPS-1];
    logic [16:0] q_reg    [0:DIV_STEPS-1];
    logic [8:0]  den_reg  [0:DIV_STEPS-1];
    logic [24:0] dividend;

    assign dividend = {num, 16'b0} + {17'b0, den[8:1]};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [8:0]  rem_in;
        logic [16:0] low_in;
        logic [16:0] q_in;
        logic [8:0]  den_in;
        logic [9:0]  trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, dividend[24:17]};
            assign low_in = dividend[16:0];
            assign q_in   = '0;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, low_in[16]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? 9'(trial - {1'b0, den_in}) : trial[8:0];
                low_reg[k] <= {low_in[15:0], 1'b0};
                q_reg[k]   <= {q_in[15:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quot = q_reg[DIV_STEPS-1];

endmodule

FILE: rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a 32-bit turn fraction in Q1.16.
// Depends on uvs_pkg; one iteration a stage plus a quadrant/round stage.
module uvs_cordic
    import uvs_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] ang,
    output trig_t       sin_q,
    output trig_t       cos_q
);

    localparam int NS = (STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : STEPS;

    logic signed [33:0] x_reg    [0:NS-1];
    logic signed [33:0] y_reg    [0:NS-1];
    logic signed [32:0] z_reg    [0:NS-1];
    logic [1:0]         quad_reg [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_iter
        logic signed [33:0] xi;
        logic signed [33:0] yi;
        logic signed [32:0] zi;
        logic [1:0]         qi;
        logic signed [32:0] at;

        if (k == 0) begin : g_first
            assign xi = 34'sh026DD3B6A;
            assign yi = '0;
            assign zi = signed'({3'b0, ang[29:0]});
            assign qi = ang[31:30];
        end else begin : g_next
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
            assign qi = quad_reg[k-1];
        end

        assign at = signed'({1'b0, atan_turn(5'(k))});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[32])
                begin
                    x_reg[k] <= xi - (yi >>> k);
                    y_reg[k] <= yi + (xi >>> k);
                    z_reg[k] <= zi - at;
                end
                else
                begin
                    x_reg[k] <= xi + (yi >>> k);
                    y_reg[k] <= yi - (xi >>> k);
                    z_reg[k] <= zi + at;
                end
                quad_reg[k] <= qi;
            end
        end
    end

    logic signed [33:0] c_raw, s_raw, c_rnd, s_rnd;
    trig_t              sin_next, cos_next;
    trig_t              sin_reg, cos_reg;

    always_comb
    begin
        case (quad_reg[NS-1])
            2'd0:    begin c_raw = x_reg[NS-1];  s_raw = y_reg[NS-1];  end
            2'd1:    begin c_raw = -y_reg[NS-1]; s_raw = x_reg[NS-1];  end
            2'd2:    begin c_raw = -x_reg[NS-1]; s_raw = -y_reg[NS-1]; end
            default: begin c_raw = y_reg[NS-1];  s_raw = -x_reg[NS-1]; end
        endcase
        c_rnd = (c_raw + 34'sd8192) >>> 14;
        s_rnd = (s_raw + 34'sd8192) >>> 14;
        if (c_rnd > 34'sd65536)
            cos_next = 18'sd65536;
        else if (c_rnd < -34'sd65536)
            cos_next = -18'sd65536;
        else
            cos_next = 18'(c_rnd);
        if (s_rnd > 34'sd65536)
            sin_next = 18'sd65536;
        else if (s_rnd < -34'sd65536)
            sin_next = -18'sd65536;
        else
            sin_next = 18'(s_rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

FILE: rtl/uv_sphere_quad_tessellator.sv
// Top level of the UV sphere quad tessellator: vertex sequencer, U/V dividers,
// CORDIC units, radius multipliers and output register.
// Depends on uvs_pkg, uvs_div, uvs_cordic.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, stack_index, slice_index | into block
//  out     | out_valid/out_ready, pos_x/y/z, tex_u/v, last_vertex | out of block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | into block
//
// One quad transfer yields six vertex transfers, one per cycle while the output
// is not stalled; the vertex sequencer accepts the next quad as it issues the
// last vertex of the current one.
// Reset restores radius 256 and 16 stacks, 16 slices and empties the pipeline.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module uv_sphere_quad_tessellator
    import uvs_pkg::*;
#(
    parameter int MAX_STACKS   = 256,
    parameter int MAX_SLICES   = 256,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stack_index,
    input  logic [7:0]  slice_index,
    output logic        out_valid,
    input  logic        out_ready,
    output coord_t      pos_x,
    output coord_t      pos_y,
    output coord_t      pos_z,
    output logic [16:0] tex_u,
    output logic [16:0] tex_v,
    output logic        last_vertex
);

    localparam int NS       = (CORDIC_STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS
                                                                : CORDIC_STEPS;
    localparam int CORD_LAT = NS + 1;
    localparam int VLD_LAT  = DIV_STEPS + CORD_LAT + 2;
    localparam int TEX_LAT  = CORD_LAT + 2;

    logic [15:0] radius_reg;
    logic [8:0]  stacks_reg, slices_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            stacks_reg <= 9'd16;
            slices_reg <= 9'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_STACKS: stacks_reg <= cfg_data[8:0];
                REG_SLICES: slices_reg <= cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    // effective counts and index clamp
    logic [8:0] ns_eff, nl_eff, i_clamp, j_clamp;

    always_comb
    begin
        if (stacks_reg == 9'd0)
            ns_eff = 9'd1;
        else if ({4'b0, stacks_reg} > 13'(MAX_STACKS))
            ns_eff = 9'(MAX_STACKS);
        else
            ns_eff = stacks_reg;
        if (slices_reg == 9'd0)
            nl_eff = 9'd1;
        else if ({4'b0, slices_reg} > 13'(MAX_SLICES))
            nl_eff = 9'(MAX_SLICES);
        else
            nl_eff = slices_reg;
        i_clamp = ({1'b0, stack_index} > ns_eff - 9'd1) ? ns_eff - 9'd1
                                                          : {1'b0, stack_index};
        j_clamp = ({1'b0, slice_index} > nl_eff - 9'd1) ? nl_eff - 9'd1
                                                          : {1'b0, slice_index};
    end

    logic en;
    logic out_valid_reg;

    assign en = !out_valid_reg || out_ready;

    // vertex sequencer
    logic       busy_reg;
    logic [2:0] slot_reg;
    logic [8:0] i_reg, j_reg;
    logic       seq_last;
    logic [8:0] vtx_a, vtx_b;

    assign seq_last = slot_reg == LAST_SLOT;
    assign in_ready = en && (!busy_reg || seq_last);
    assign vtx_a    = i_reg + {8'b0, ROW_STEP[slot_reg]};
    assign vtx_b    = j_reg + {8'b0, COL_STEP[slot_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (en)
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                slot_reg <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !seq_last;
                slot_reg <= seq_last ? 3'd0 : slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid && in_ready)
        begin
            i_reg <= i_clamp;
            j_reg <= j_clamp;
        end
    end

    // valid and last travel alongside the data
    logic vld_reg  [0:VLD_LAT-1];
    logic last_reg [0:VLD_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VLD_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= busy_reg;
            for (int k = 1; k < VLD_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[0] <= seq_last;
            for (int k = 1; k < VLD_LAT; k++)
                last_reg[k] <= last_reg[k-1];
        end
    end

    // U and V
    logic [16:0] u_q, v_q;

    uvs_div u_div_u (.clk(clk), .en(en), .num(vtx_b), .den(nl_eff), .quot(u_q));
    uvs_div u_div_v (.clk(clk), .en(en), .num(vtx_a), .den(ns_eff), .quot(v_q));

    logic [16:0] u_dly_reg [0:TEX_LAT-1];
    logic [16:0] v_dly_reg [0:TEX_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dly_reg[0] <= u_q;
            v_dly_reg[0] <= v_q;
            for (int k = 1; k < TEX_LAT; k++)
            begin
                u_dly_reg[k] <= u_dly_reg[k-1];
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
        end
    end

    // sine and cosine of theta and phi
    trig_t st, ct, sp, cp;

    uvs_cordic #(.STEPS(NS)) u_cordic_theta (
        .clk(clk), .en(en), .ang({u_q[15:0], 16'b0}), .sin_q(st), .cos_q(ct)
    );
    uvs_cordic #(.STEPS(NS)) u_cordic_phi (
        .clk(clk), .en(en), .ang({v_q, 15'b0}), .sin_q(sp), .cos_q(cp)
    );

    // radius products
    logic signed [16:0] r_s;
    logic signed [34:0] rs_reg, rc_reg, rc2_reg;
    trig_t              st_reg, ct_reg;
    logic signed [52:0] px_reg, pz_reg;

    assign r_s = signed'({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg  <= 35'(r_s) * 35'(sp);
            rc_reg  <= 35'(r_s) * 35'(cp);
            st_reg  <= st;
            ct_reg  <= ct;
            px_reg  <= 53'(rs_reg) * 53'(ct_reg);
            pz_reg  <= 53'(rs_reg) * 53'(st_reg);
            rc2_reg <= rc_reg;
        end
    end

    // rounding and saturation
    logic signed [52:0] px_rnd, pz_rnd;
    logic signed [34:0] py_rnd;
    coord_t             px_next, py_next, pz_next;

    always_comb
    begin
        px_rnd = (px_reg + 53'sd2147483648) >>> 32;
        pz_rnd = (pz_reg + 53'sd2147483648) >>> 32;
        py_rnd = (rc2_reg + 35'sd32768) >>> 16;
        if (px_rnd > 53'sd65535)
            px_next = 17'sd65535;
        else if (px_rnd < -53'sd65535)
            px_next = -17'sd65535;
        else
            px_next = 17'(px_rnd);
        if (pz_rnd > 53'sd65535)
            pz_next = 17'sd65535;
        else if (pz_rnd < -53'sd65535)
            pz_next = -17'sd65535;
        else
            pz_next = 17'(pz_rnd);
        if (py_rnd > 35'sd65535)
            py_next = 17'sd65535;
        else if (py_rnd < -35'sd65535)
            py_next = -17'sd65535;
        else
            py_next = 17'(py_rnd);
    end

    // output register
    coord_t      px_out_reg, py_out_reg, pz_out_reg;
    logic [16:0] u_out_reg, v_out_reg;
    logic        last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[VLD_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_out_reg   <= px_next;
            py_out_reg   <= py_next;
            pz_out_reg   <= pz_next;
            u_out_reg    <= u_dly_reg[TEX_LAT-1];
            v_out_reg    <= v_dly_reg[TEX_LAT-1];
            last_out_reg <= last_reg[VLD_LAT-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = px_out_reg;
    assign pos_y       = py_out_reg;
    assign pos_z       = pz_out_reg;
    assign tex_u       = u_out_reg;
    assign tex_v       = v_out_reg;
    assign last_vertex = last_out_reg;

endmodule

FILE: rtl/uvs_checker.sv
// Port-level checks for the UV sphere quad tessellator, bound to its top level.
// Depends on uvs_pkg and uv_sphere_quad_tessellator.
module uvs_checker
    import uvs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input coord_t      pos_x,
    input coord_t      pos_y,
    input coord_t      pos_z,
    input logic [16:0] tex_u,
    input logic [16:0] tex_v
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(tex_u))
        else $error("output transfer changed while stalled");

    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
        else $error("texture coordinate above one");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_x != 17'h10000 && pos_y != 17'h10000 && pos_z != 17'h10000)
        else $error("position not saturated");

endmodule

bind uv_sphere_quad_tessellator uvs_checker u_uvs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .tex_u(tex_u),
    .tex_v(tex_v)
);

FILE: tb/tb_top.sv
// Testbench for uv_sphere_quad_tessellator: directed and random quads with a
// bit-exact vertex predictor and a scoreboard. Depends on uvs_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
    import uvs_pkg::*;

    localparam int ROT_STEPS  = 16;
    localparam int DRAIN_WAIT = 60;
    localparam int CYCLE_CAP  = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [16:0] u;
        logic [16:0] v;
        logic        last;
    } vertex_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stack_index;
    logic [7:0]  slice_index;
    logic        out_valid;
    logic        out_ready;
    coord_t      pos_x;
    coord_t      pos_y;
    coord_t      pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        last_vertex;

    vertex_t     vertex_q[$];
    longint      radius_m;
    int          stacks_m;
    int          slices_m;
    int          mismatches;
    int          vertices_seen;
    int          quads_sent;
    int          cycles;
    bit          calm;

    longint atan_lut[24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    uv_sphere_quad_tessellator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .stack_index(stack_index), .slice_index(slice_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tex_u(tex_u), .tex_v(tex_v), .last_vertex(last_vertex)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint clip(input longint val, input longint lo, input longint hi);
        return val < lo ? lo : (val > hi ? hi : val);
    endfunction

    function automatic void sin_cos(input logic [31:0] ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 64'sh26DD3B6A;
        y = 0;
        z = longint'(ang[29:0]);
        for (int k = 0; k < ROT_STEPS && k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_lut[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_lut[k];
            end
        end
        case (ang[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        s = clip((s + 8192) >>> 14, -65536, 65536);
        c = clip((c + 8192) >>> 14, -65536, 65536);
    endfunction

    function automatic vertex_t grid_vertex(input int a, input int b, input int ns,
                                            input int nl, input bit last);
        vertex_t vx;
        longint  uu;
        longint  vv;
        longint  st;
        longint  ct;
        longint  sp;
        longint  cp;
        logic [31:0] theta;
        logic [31:0] phi;
        uu = (longint'(b) * 65536 + nl / 2) / nl;
        vv = (longint'(a) * 65536 + ns / 2) / ns;
        theta = 32'(uu << 16);
        phi = 32'(vv << 15);
        sin_cos(theta, st, ct);
        sin_cos(phi, sp, cp);
        vx.x = coord_t'(clip((radius_m * sp * ct + (64'sd1 << 31)) >>> 32, -65535, 65535));
        vx.z = coord_t'(clip((radius_m * sp * st + (64'sd1 << 31)) >>> 32, -65535, 65535));
        vx.y = coord_t'(clip((radius_m * cp + 32768) >>> 16, -65535, 65535));
        vx.u = 17'(uu);
        vx.v = 17'(vv);
        vx.last = last;
        return vx;
    endfunction

    function automatic void predict_quad(input int i_in, input int j_in);
        int ns;
        int nl;
        int i;
        int j;
        ns = stacks_m == 0 ? 1 : (stacks_m > 256 ? 256 : stacks_m);
        nl = slices_m == 0 ? 1 : (slices_m > 256 ? 256 : slices_m);
        i = i_in > ns - 1 ? ns - 1 : i_in;
        j = j_in > nl - 1 ? nl - 1 : j_in;
        vertex_q.insert(vertex_q.size(), grid_vertex(i,     j,     ns, nl, 1'b0));
        vertex_q.insert(vertex_q.size(), grid_vertex(i + 1, j,     ns, nl, 1'b0));
        vertex_q.insert(vertex_q.size(), grid_vertex(i,     j + 1, ns, nl, 1'b0));
        vertex_q.insert(vertex_q.size(), grid_vertex(i + 1, j,     ns, nl, 1'b0));
        vertex_q.insert(vertex_q.size(), grid_vertex(i + 1, j + 1, ns, nl, 1'b0));
        vertex_q.insert(vertex_q.size(), grid_vertex(i,     j + 1, ns, nl, 1'b1));
    endfunction

    // output side: random backpressure and scoreboard
    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex};
            vertices_seen++;
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d z=%0d u=%0d v=%0d last=%0b",
                             got.x, got.y, got.z, got.u, got.v, got.last);
            end
            else
            begin
                exp_v = vertex_q.pop_front();
                if (got.x !== exp_v.x || got.y !== exp_v.y || got.z !== exp_v.z ||
                    got.u !== exp_v.u || got.v !== exp_v.v || got.last !== exp_v.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"vertex %0d: exp x=%0d y=%0d z=%0d u=%0d v=%0d ",
                                  "last=%0b, got x=%0d y=%0d z=%0d u=%0d v=%0d last=%0b"},
                                 vertices_seen, exp_v.x, exp_v.y, exp_v.z, exp_v.u,
                                 exp_v.v, exp_v.last, got.x, got.y, got.z, got.u,
                                 got.v, got.last);
                end
            end
        end
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS: radius_m = data;
            REG_STACKS: stacks_m = data[8:0];
            REG_SLICES: slices_m = data[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [15:0] r, input logic [15:0] ns, input logic [15:0] nl);
        wait_idle();
        write_reg(REG_RADIUS, r);
        write_reg(REG_STACKS, ns);
        write_reg(REG_SLICES, nl);
    endtask

    task automatic send_quad(input logic [7:0] i, input logic [7:0] j);
        if (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        stack_index <= i;
        slice_index <= j;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_quad(i, j);
        quads_sent++;
    endtask

    task automatic test_reset_defaults();
        send_quad(8'd0, 8'd0);
        send_quad(8'd15, 8'd15);
        send_quad(8'd255, 8'd255);
        send_quad(8'd7, 8'd3);
    endtask

    task automatic test_full_grid();
        set_grid(16'hFFFF, 16'd256, 16'd256);
        send_quad(8'd0, 8'd0);
        send_quad(8'd255, 8'd255);
        send_quad(8'd128, 8'd64);
        send_quad(8'hAA, 8'h55);
        send_quad(8'h55, 8'hAA);
        send_quad(8'd0, 8'd255);
    endtask

    task automatic test_count_limits();
        set_grid(16'd0, 16'd0, 16'd0);
        send_quad(8'd3, 8'd9);
        set_grid(16'd1000, 16'h01FF, 16'd1);
        send_quad(8'd255, 8'd200);
        send_quad(8'd1, 8'd0);
        set_grid(16'h8000, 16'hFE02, 16'd3);
        send_quad(8'd1, 8'd2);
        send_quad(8'd200, 8'd200);
        wait_idle();
        write_reg(REG_UNUSED, 16'h0005);
        send_quad(8'd0, 8'd1);
        send_quad(8'd1, 8'd0);
    endtask

    task automatic test_random_quads();
        int ns;
        int nl;
        for (int phase = 0; phase < 8; phase++)
        begin
            ns = $urandom_range(256, 1);
            nl = $urandom_range(256, 1);
            if (phase == 0)
            begin
                ns = 2;
                nl = 3;
            end
            set_grid(phase == 7 ? 16'hFFFF : 16'($urandom_range(65535)),
                     16'(ns) | ($urandom_range(1) ? 16'h0 : 16'($urandom) & 16'hFE00),
                     16'(nl));
            calm = (phase == 4);
            for (int n = 0; n < 19; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_quad(8'($urandom), 8'($urandom));
                else
                    send_quad(8'($urandom_range(ns - 1)), 8'($urandom_range(nl - 1)));
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        in_valid = 1'b0;
        stack_index = '0;
        slice_index = '0;
        out_ready = 1'b0;
        radius_m = 256;
        stacks_m = 16;
        slices_m = 16;
        mismatches = 0;
        vertices_seen = 0;
        quads_sent = 0;
        cycles = 0;
        calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_grid();
        test_count_limits();
        test_random_quads();

        wait_idle();
        $display("%0d quads sent, %0d vertices checked over default, extreme and random grids",
                 quads_sent, vertices_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
